// ----- sv/aad_pkg.sv -----
// Package for the accessory attach detector: field widths, codes, state type.
// No dependencies; used by the interfaces, the top level and the checker.
package aad_pkg;

    localparam int unsigned TimeW  = 48;
    localparam int unsigned MvW    = 12;
    localparam int unsigned DebW   = 22;
    localparam int unsigned PulseW = 16;
    localparam int unsigned LenW   = 32;
    localparam int unsigned FuncW  = 3;
    localparam int unsigned IdxW   = 3;
    localparam int unsigned CfgW   = 22;

    localparam logic [DebW-1:0] DelayMax = {DebW{1'b1}};

    typedef enum logic [FuncW-1:0] {
        FN_EDGE         = 3'd0,
        FN_EXPIRY       = 3'd1,
        FN_STARTUP      = 3'd2,
        FN_SHUTDOWN     = 3'd3,
        FN_FORCE_ATTACH = 3'd4,
        FN_FORCE_DETACH = 3'd5,
        FN_FORCE_RESET  = 3'd6,
        FN_UNUSED       = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_UNKNOWN      = 2'd0,
        ST_DISCONNECTED = 2'd1,
        ST_CONNECTED    = 2'd2
    } status_t;

    typedef enum logic [IdxW-1:0] {
        REG_ATTACH_MAX   = 3'd0,
        REG_DETACH_MIN   = 3'd1,
        REG_ASSERT_DEB   = 3'd2,
        REG_DEASSERT_DEB = 3'd3,
        REG_PULSE_MIN    = 3'd4,
        REG_PULSE_MAX    = 3'd5
    } reg_idx_t;

    localparam logic [MvW-1:0]    AttachMaxRst   = 12'd400;
    localparam logic [MvW-1:0]    DetachMinRst   = 12'd2700;
    localparam logic [DebW-1:0]   AssertDebRst   = 22'd350000;
    localparam logic [DebW-1:0]   DeassertDebRst = 22'd20000;
    localparam logic [PulseW-1:0] PulseMinRst    = 16'd400;
    localparam logic [PulseW-1:0] PulseMaxRst    = 16'd650;

endpackage

// ----- sv/aad_evt_if.sv -----
// Event channel (valid/ready) carrying one timestamped detector event.
// Depends on aad_pkg for field widths.
interface aad_evt_if;
    logic                        valid;
    logic                        ready;
    logic [aad_pkg::FuncW-1:0]   func;
    logic [aad_pkg::TimeW-1:0]   time_us;
    logic                        pin_level;
    logic [aad_pkg::MvW-1:0]     adc_mv;

    modport source (output valid, func, time_us, pin_level, adc_mv, input ready);
    modport sink   (input valid, func, time_us, pin_level, adc_mv, output ready);
endinterface

// ----- sv/aad_res_if.sv -----
// Result channel (valid/ready) carrying one detector status word.
// Depends on aad_pkg for field widths.
interface aad_res_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                dock_state;
    logic                      slate_mode;
    logic                      base_power_enable;
    logic                      wake_event;
    logic                      timer_request;
    logic [aad_pkg::DebW-1:0]  timer_delay_us;
    logic                      irq_enabled;

    modport source (output valid, dock_state, slate_mode, base_power_enable, wake_event,
                    timer_request, timer_delay_us, irq_enabled, input ready);
    modport sink   (input valid, dock_state, slate_mode, base_power_enable, wake_event,
                    timer_request, timer_delay_us, irq_enabled, output ready);
endinterface

// ----- sv/aad_cfg_if.sv -----
// Configuration write channel (valid/ready) with register index and data.
// Depends on aad_pkg for field widths.
interface aad_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [aad_pkg::IdxW-1:0]  index;
    logic [aad_pkg::CfgW-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/accessory_attach_detector.sv -----
// Attach detector top level: event input register, one-pass update, result register.
// An accepted event word waits in the input register and is written to the result register once that is empty or taken.
// Throughput: one event word per cycle while the result side keeps taking words; the result register frees the input
// register whenever the result side takes a word or is empty.
// Reset (rst_n low, async): status unknown, deadline/pulse cleared, edges disabled,
// configuration back to defaults, both pipeline registers empty.
module accessory_attach_detector (
    input  logic          clk,
    input  logic          rst_n,
    aad_evt_if.sink       evt,
    aad_res_if.source     res,
    aad_cfg_if.sink       cfg
);

    // configuration
    logic [aad_pkg::MvW-1:0]    attach_max_reg;
    logic [aad_pkg::MvW-1:0]    detach_min_reg;
    logic [aad_pkg::DebW-1:0]   assert_deb_reg;
    logic [aad_pkg::DebW-1:0]   deassert_deb_reg;
    logic [aad_pkg::PulseW-1:0] pulse_min_reg;
    logic [aad_pkg::PulseW-1:0] pulse_max_reg;

    // detector state
    aad_pkg::status_t           status_reg, status_next;
    logic [aad_pkg::TimeW-1:0]  deadline_reg, deadline_next;
    logic [aad_pkg::TimeW-1:0]  start_reg, start_next;
    logic [aad_pkg::LenW-1:0]   length_reg, length_next;
    logic                       irq_on_reg, irq_on_next;

    // input register
    logic                       s1_valid_reg;
    aad_pkg::func_t             s1_func_reg;
    logic [aad_pkg::TimeW-1:0]  s1_time_reg;
    logic                       s1_pin_reg;
    logic [aad_pkg::MvW-1:0]    s1_mv_reg;

    // result register
    logic                       res_valid_reg;
    aad_pkg::status_t           res_status_reg;
    logic                       res_wake_reg, wake_next;
    logic                       res_treq_reg, treq_next;
    logic [aad_pkg::DebW-1:0]   res_delay_reg, delay_next;
    logic                       res_irq_reg;

    logic                       advance;
    logic                       evt_take;

    logic [aad_pkg::DebW-1:0]   deb;
    logic [aad_pkg::TimeW:0]    dl_sum;
    logic [aad_pkg::TimeW-1:0]  dl_sat;
    logic [aad_pkg::TimeW-1:0]  remain;
    logic [aad_pkg::TimeW-1:0]  elapsed;
    logic                       past_deadline;
    logic                       pulse_ok;

    assign advance  = s1_valid_reg && (!res_valid_reg || res.ready);
    assign evt.ready = !s1_valid_reg || advance;
    assign evt_take = evt.valid && evt.ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            attach_max_reg   <= aad_pkg::AttachMaxRst;
            detach_min_reg   <= aad_pkg::DetachMinRst;
            assert_deb_reg   <= aad_pkg::AssertDebRst;
            deassert_deb_reg <= aad_pkg::DeassertDebRst;
            pulse_min_reg    <= aad_pkg::PulseMinRst;
            pulse_max_reg    <= aad_pkg::PulseMaxRst;
        end
        else if (cfg.valid) begin
            case (cfg.index)
                aad_pkg::REG_ATTACH_MAX:   attach_max_reg   <= cfg.data[aad_pkg::MvW-1:0];
                aad_pkg::REG_DETACH_MIN:   detach_min_reg   <= cfg.data[aad_pkg::MvW-1:0];
                aad_pkg::REG_ASSERT_DEB:   assert_deb_reg   <= cfg.data[aad_pkg::DebW-1:0];
                aad_pkg::REG_DEASSERT_DEB: deassert_deb_reg <= cfg.data[aad_pkg::DebW-1:0];
                aad_pkg::REG_PULSE_MIN:    pulse_min_reg    <= cfg.data[aad_pkg::PulseW-1:0];
                aad_pkg::REG_PULSE_MAX:    pulse_max_reg    <= cfg.data[aad_pkg::PulseW-1:0];
                default: ;
            endcase
        end
    end

    // shared datapath terms
    assign deb           = s1_pin_reg ? assert_deb_reg : deassert_deb_reg;
    assign dl_sum        = {1'b0, s1_time_reg} + {{(aad_pkg::TimeW+1-aad_pkg::DebW){1'b0}}, deb};
    assign dl_sat        = dl_sum[aad_pkg::TimeW] ? {aad_pkg::TimeW{1'b1}}
                                                  : dl_sum[aad_pkg::TimeW-1:0];
    assign past_deadline = deadline_reg <= s1_time_reg;
    assign remain        = deadline_reg - s1_time_reg;
    assign elapsed       = s1_time_reg - start_reg;
    assign pulse_ok      = (length_reg >= {16'd0, pulse_min_reg})
                        && (length_reg <= {16'd0, pulse_max_reg});

    always_comb begin
        status_next   = status_reg;
        deadline_next = deadline_reg;
        start_next    = start_reg;
        length_next   = length_reg;
        irq_on_next   = irq_on_reg;
        wake_next     = 1'b0;
        treq_next     = 1'b0;
        delay_next    = '0;
        case (s1_func_reg)
            aad_pkg::FN_EDGE: begin
                if (irq_on_reg) begin
                    if (past_deadline) begin
                        start_next  = (status_reg == aad_pkg::ST_CONNECTED && !s1_pin_reg)
                                    ? s1_time_reg : '0;
                        length_next = '0;
                        treq_next   = 1'b1;
                        delay_next  = deb;
                    end
                    else if (status_reg == aad_pkg::ST_CONNECTED && s1_pin_reg
                             && length_reg == '0 && start_reg != '0) begin
                        length_next = elapsed[aad_pkg::LenW-1:0];
                    end
                    else begin
                        start_next  = '0;
                        length_next = '0;
                    end
                    deadline_next = dl_sat;
                end
            end
            aad_pkg::FN_EXPIRY: begin
                if (!past_deadline) begin
                    treq_next  = 1'b1;
                    delay_next = (remain > {{(aad_pkg::TimeW-aad_pkg::DebW){1'b0}},
                                            aad_pkg::DelayMax})
                               ? aad_pkg::DelayMax : remain[aad_pkg::DebW-1:0];
                end
                else begin
                    // detached test wins when thresholds overlap
                    if (s1_mv_reg >= detach_min_reg) begin
                        status_next = aad_pkg::ST_DISCONNECTED;
                    end
                    else if (s1_mv_reg <= attach_max_reg) begin
                        if (status_reg != aad_pkg::ST_CONNECTED) begin
                            status_next = aad_pkg::ST_CONNECTED;
                        end
                        else begin
                            wake_next = pulse_ok;
                        end
                    end
                    else begin
                        wake_next = 1'b1;
                    end
                    irq_on_next = 1'b1;
                end
            end
            aad_pkg::FN_STARTUP: begin
                irq_on_next = 1'b1;
                treq_next   = 1'b1;
                delay_next  = {{(aad_pkg::DebW-aad_pkg::PulseW){1'b0}}, pulse_min_reg};
            end
            aad_pkg::FN_SHUTDOWN, aad_pkg::FN_FORCE_ATTACH, aad_pkg::FN_FORCE_DETACH: begin
                irq_on_next = 1'b0;
                status_next = aad_pkg::ST_DISCONNECTED;
            end
            aad_pkg::FN_FORCE_RESET: begin
                irq_on_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            status_reg    <= aad_pkg::ST_UNKNOWN;
            deadline_reg  <= '0;
            start_reg     <= '0;
            length_reg    <= '0;
            irq_on_reg    <= 1'b0;
        end
        else begin
            if (evt.ready) begin
                s1_valid_reg <= evt.valid;
            end
            if (advance) begin
                res_valid_reg <= 1'b1;
                status_reg    <= status_next;
                deadline_reg  <= deadline_next;
                start_reg     <= start_next;
                length_reg    <= length_next;
                irq_on_reg    <= irq_on_next;
            end
            else if (res.ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (evt_take) begin
            s1_func_reg <= aad_pkg::func_t'(evt.func);
            s1_time_reg <= evt.time_us;
            s1_pin_reg  <= evt.pin_level;
            s1_mv_reg   <= evt.adc_mv;
        end
        if (advance) begin
            res_status_reg <= status_next;
            res_wake_reg   <= wake_next;
            res_treq_reg   <= treq_next;
            res_delay_reg  <= delay_next;
            res_irq_reg    <= irq_on_next;
        end
    end

    assign res.valid             = res_valid_reg;
    assign res.dock_state        = res_status_reg;
    assign res.slate_mode        = res_status_reg != aad_pkg::ST_CONNECTED;
    assign res.base_power_enable = res_status_reg == aad_pkg::ST_CONNECTED;
    assign res.wake_event        = res_wake_reg;
    assign res.timer_request     = res_treq_reg;
    assign res.timer_delay_us    = res_delay_reg;
    assign res.irq_enabled       = res_irq_reg;

endmodule

// ----- sv/aad_checker.sv -----
// Port-level checks on the attach detector's result channel, bound to the top level.
// Depends on aad_pkg and accessory_attach_detector.
module aad_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      res_valid,
    input logic                      res_ready,
    input logic [1:0]                dock_state,
    input logic                      slate_mode,
    input logic                      base_power_enable,
    input logic                      timer_request,
    input logic [aad_pkg::DebW-1:0]  timer_delay_us
);

    // a stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(dock_state)
                                   && $stable(timer_delay_us))
        else $error("result word changed while stalled");

    a_mode_power: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (slate_mode != base_power_enable)
                   && (base_power_enable == (dock_state == aad_pkg::ST_CONNECTED)))
        else $error("slate mode / base power disagree with dock state");

    a_delay_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !timer_request |-> timer_delay_us == '0)
        else $error("timer delay without timer request");

    a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> dock_state != 2'd3)
        else $error("dock state code out of range");

endmodule

bind accessory_attach_detector aad_checker u_aad_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .dock_state       (res.dock_state),
    .slate_mode       (res.slate_mode),
    .base_power_enable(res.base_power_enable),
    .timer_request    (res.timer_request),
    .timer_delay_us   (res.timer_delay_us)
);

// ----- bench/testbench.sv -----
// Testbench for accessory_attach_detector: drives timestamped detector events and
// register writes, predicts each status word and compares it field by field.
// Depends on aad_pkg, the three channel interfaces and the detector top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [aad_pkg::TimeW-1:0]  time_t;
    typedef logic [aad_pkg::MvW-1:0]    mv_t;
    typedef logic [aad_pkg::DebW-1:0]   delay_t;
    typedef logic [aad_pkg::PulseW-1:0] pulse_t;
    typedef logic [aad_pkg::CfgW-1:0]   cfg_t;

    localparam int unsigned IdleLimit  = 4000;
    localparam int unsigned HoldCycles = 300;
    localparam int unsigned MaxPrint   = 20;
    localparam time_t TimeMax = {aad_pkg::TimeW{1'b1}};

    typedef struct {
        logic [1:0]      dock;
        logic            slate;
        logic            power;
        logic            wake;
        logic            treq;
        delay_t          delay;
        logic            irq;
    } status_word_t;

    typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic clk;
    logic rst_n;

    aad_evt_if evt_ch();
    aad_res_if res_ch();
    aad_cfg_if cfg_ch();

    accessory_attach_detector DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // detector registers and state as this bench expects them
    mv_t                  attach_max_mv   = aad_pkg::AttachMaxRst;
    mv_t                  detach_min_mv   = aad_pkg::DetachMinRst;
    delay_t               assert_deb_us   = aad_pkg::AssertDebRst;
    delay_t               deassert_deb_us = aad_pkg::DeassertDebRst;
    pulse_t               pulse_min_us    = aad_pkg::PulseMinRst;
    pulse_t               pulse_max_us    = aad_pkg::PulseMaxRst;
    aad_pkg::status_t     exp_status      = aad_pkg::ST_UNKNOWN;
    time_t                deb_deadline    = '0;
    time_t                exp_pulse_t0    = '0;
    logic [aad_pkg::LenW-1:0] pulse_len   = '0;
    logic                 edges_on        = 1'b0;

    status_word_t     words_due[$];
    status_word_t     want_word;
    status_word_t     got_word;
    time_t            cur_time = '0;

    bit       tx_bursty    = 1'b1;
    int       burst_left   = 0;
    bit       hold_request = 1'b0;
    int       hold_left    = 0;
    rx_mode_t rx_mode      = RX_FREE;
    int       mode_left    = 0;
    logic [7:0] stall_pattern = 8'hFF;

    int n_events  = 0;
    int n_ignored = 0;
    int n_words   = 0;
    int n_wake    = 0;
    int n_treq    = 0;
    int n_errors  = 0;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic predict_word(input aad_pkg::func_t fn, input time_t t, input logic pin,
                                input mv_t mv, output status_word_t w);
        delay_t                  deb;
        logic [aad_pkg::TimeW:0] sum;
        time_t                   diff;
        w.wake  = 1'b0;
        w.treq  = 1'b0;
        w.delay = '0;
        case (fn)
            aad_pkg::FN_EDGE:
                if (edges_on)
                begin
                    deb = pin ? assert_deb_us : deassert_deb_us;
                    if (deb_deadline <= t)
                    begin
                        exp_pulse_t0 = (exp_status == aad_pkg::ST_CONNECTED && !pin) ? t : '0;
                        pulse_len    = '0;
                        w.treq       = 1'b1;
                        w.delay      = deb;
                    end
                    else if (exp_status == aad_pkg::ST_CONNECTED && pin && pulse_len == 0 &&
                             exp_pulse_t0 != 0)
                    begin
                        // rising edge closes the wake pulse, length kept to 32 bits
                        diff      = t - exp_pulse_t0;
                        pulse_len = diff[aad_pkg::LenW-1:0];
                    end
                    else
                    begin
                        exp_pulse_t0 = '0;
                        pulse_len    = '0;
                    end
                    sum = {1'b0, t} + {{(aad_pkg::TimeW+1-aad_pkg::DebW){1'b0}}, deb};
                    deb_deadline = sum[aad_pkg::TimeW] ? TimeMax : sum[aad_pkg::TimeW-1:0];
                end
            aad_pkg::FN_EXPIRY:
                if (deb_deadline > t)
                begin
                    diff    = deb_deadline - t;
                    w.treq  = 1'b1;
                    w.delay = (diff > time_t'(aad_pkg::DelayMax)) ? aad_pkg::DelayMax
                                                                  : diff[aad_pkg::DebW-1:0];
                end
                else
                begin
                    // detached threshold wins when the two overlap
                    if (mv >= detach_min_mv)
                        exp_status = aad_pkg::ST_DISCONNECTED;
                    else if (mv <= attach_max_mv)
                    begin
                        if (exp_status != aad_pkg::ST_CONNECTED)
                            exp_status = aad_pkg::ST_CONNECTED;
                        else if (pulse_len >= {{(aad_pkg::LenW-aad_pkg::PulseW){1'b0}},
                                               pulse_min_us} &&
                                 pulse_len <= {{(aad_pkg::LenW-aad_pkg::PulseW){1'b0}},
                                               pulse_max_us})
                            w.wake = 1'b1;
                    end
                    else
                        w.wake = 1'b1;
                    edges_on = 1'b1;
                end
            aad_pkg::FN_STARTUP:
            begin
                edges_on = 1'b1;
                w.treq   = 1'b1;
                w.delay  = {{(aad_pkg::DebW-aad_pkg::PulseW){1'b0}}, pulse_min_us};
            end
            aad_pkg::FN_SHUTDOWN, aad_pkg::FN_FORCE_ATTACH, aad_pkg::FN_FORCE_DETACH:
            begin
                edges_on   = 1'b0;
                exp_status = aad_pkg::ST_DISCONNECTED;
            end
            aad_pkg::FN_FORCE_RESET:
                edges_on = 1'b1;
            default: ;
        endcase
        w.dock  = exp_status;
        w.slate = (exp_status != aad_pkg::ST_CONNECTED);
        w.power = (exp_status == aad_pkg::ST_CONNECTED);
        w.irq   = edges_on;
    endtask

    function automatic void check_field(input string name, input time_t want,
                                        input time_t got);
        if (want !== got)
        begin
            n_errors++;
            if (n_errors <= MaxPrint)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic time_t past_deadline();
        return (deb_deadline > cur_time) ? deb_deadline : cur_time;
    endfunction

    function automatic mv_t rand_mv();
        return mv_t'($urandom_range(4095, 0));
    endfunction

    function automatic mv_t attached_mv();
        return mv_t'($urandom_range(attach_max_mv, 0));
    endfunction

    task automatic send_event(input aad_pkg::func_t fn, input time_t t, input logic pin,
                              input mv_t mv);
        status_word_t w;
        int gap;
        @(negedge clk);
        evt_ch.valid     <= 1'b1;
        evt_ch.func      <= fn;
        evt_ch.time_us   <= t;
        evt_ch.pin_level <= pin;
        evt_ch.adc_mv    <= mv;
        @(posedge clk);
        while (evt_ch.ready !== 1'b1)
            @(posedge clk);
        if (fn == aad_pkg::FN_EDGE && !edges_on)
            n_ignored++;
        else
            n_events++;
        predict_word(fn, t, pin, mv, w);
        words_due.push_back(w);
        if (w.wake)
            n_wake++;
        if (w.treq)
            n_treq++;
        if (t > cur_time)
            cur_time = t;
        if (tx_bursty)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(24, 1);
                gap = $urandom_range(8, 1);
                @(negedge clk);
                evt_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // stop sending and let every outstanding word drain out
    task automatic wait_idle();
        @(negedge clk);
        evt_ch.valid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input aad_pkg::reg_idx_t idx, input cfg_t d);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        case (idx)
            aad_pkg::REG_ATTACH_MAX:   attach_max_mv   = d[aad_pkg::MvW-1:0];
            aad_pkg::REG_DETACH_MIN:   detach_min_mv   = d[aad_pkg::MvW-1:0];
            aad_pkg::REG_ASSERT_DEB:   assert_deb_us   = d[aad_pkg::DebW-1:0];
            aad_pkg::REG_DEASSERT_DEB: deassert_deb_us = d[aad_pkg::DebW-1:0];
            aad_pkg::REG_PULSE_MIN:    pulse_min_us    = d[aad_pkg::PulseW-1:0];
            aad_pkg::REG_PULSE_MAX:    pulse_max_us    = d[aad_pkg::PulseW-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(input mv_t am, input mv_t dm,
                              input delay_t ad, input delay_t dd,
                              input pulse_t pmin, input pulse_t pmax);
        wait_idle();
        write_reg(aad_pkg::REG_ATTACH_MAX, cfg_t'(am));
        write_reg(aad_pkg::REG_DETACH_MIN, cfg_t'(dm));
        write_reg(aad_pkg::REG_ASSERT_DEB, cfg_t'(ad));
        write_reg(aad_pkg::REG_DEASSERT_DEB, cfg_t'(dd));
        write_reg(aad_pkg::REG_PULSE_MIN, cfg_t'(pmin));
        write_reg(aad_pkg::REG_PULSE_MAX, cfg_t'(pmax));
    endtask

    task automatic attach_base();
        send_event(aad_pkg::FN_STARTUP, cur_time, 1'($urandom_range(1, 0)), rand_mv());
        send_event(aad_pkg::FN_EXPIRY, past_deadline() + time_t'($urandom_range(20, 0)),
                   1'b0, attached_mv());
    endtask

    task automatic run_traffic(input int target);
        int first;
        int len;
        time_t t0;
        mv_t mv;
        first = n_events;
        while (n_events - first < target)
        begin
            if ($urandom_range(15, 0) == 0)
                tx_bursty = ~tx_bursty;
            case ($urandom_range(9, 0))
                0, 1: attach_base();
                2, 3, 4:
                begin
                    // wake pulse: low edge, high edge, sometimes another expiry, then expiry past the deadline
                    if (!edges_on)
                        send_event(aad_pkg::FN_STARTUP, cur_time, 1'b0, rand_mv());
                    if (exp_status != aad_pkg::ST_CONNECTED && $urandom_range(3, 0) != 0)
                        attach_base();
                    t0 = past_deadline() + time_t'($urandom_range(100, 0));
                    send_event(aad_pkg::FN_EDGE, t0, 1'b0, rand_mv());
                    case ($urandom_range(3, 0))
                        0: len = int'(pulse_min_us);
                        1: len = int'(pulse_max_us);
                        2: len = $urandom_range(pulse_max_us, pulse_min_us);
                        default: len = $urandom_range(pulse_max_us + 100, 0);
                    endcase
                    send_event(aad_pkg::FN_EDGE, t0 + time_t'(len), 1'b1, rand_mv());
                    if ($urandom_range(1, 0) == 1)
                        send_event(aad_pkg::FN_EXPIRY,
                                   cur_time + time_t'($urandom_range(1000, 1)), 1'b0,
                                   rand_mv());
                    send_event(aad_pkg::FN_EXPIRY,
                               past_deadline() + time_t'($urandom_range(3, 0)), 1'b0,
                               attached_mv());
                end
                5:
                begin
                    send_event(aad_pkg::FN_EDGE, past_deadline(), 1'($urandom_range(1, 0)),
                               rand_mv());
                    if ($urandom_range(1, 0) == 1)
                        mv = mv_t'($urandom_range(4095, detach_min_mv));
                    else if (attach_max_mv + 1 < detach_min_mv)
                        mv = mv_t'($urandom_range(detach_min_mv - 1, attach_max_mv + 1));
                    else
                        mv = rand_mv();
                    send_event(aad_pkg::FN_EXPIRY,
                               past_deadline() + time_t'($urandom_range(10, 0)), 1'b0, mv);
                end
                6:
                begin
                    // expiry aimed at or before the deadline; one that lands before it just rearms the timer
                    send_event(aad_pkg::FN_EDGE, past_deadline(), 1'($urandom_range(1, 0)),
                               rand_mv());
                    if (deb_deadline > cur_time)
                        t0 = cur_time + time_t'($urandom_range(32'(deb_deadline - cur_time),
                                                               0));
                    else
                        t0 = cur_time;
                    send_event(aad_pkg::FN_EXPIRY, t0, 1'($urandom_range(1, 0)), rand_mv());
                end
                default:
                begin
                    case ($urandom_range(3, 0))
                        0: t0 = time_t'($urandom);
                        1: t0 = cur_time + time_t'($urandom_range(1 << 22, 0));
                        default: t0 = cur_time + time_t'($urandom_range(2000, 0));
                    endcase
                    send_event(aad_pkg::func_t'($urandom_range(7, 0)), t0,
                               1'($urandom_range(1, 0)), rand_mv());
                end
            endcase
        end
    endtask

    task automatic test_event_basics();
        send_event(aad_pkg::FN_EDGE, 48'd100, 1'b1, '0);            // edges still disabled
        send_event(aad_pkg::FN_UNUSED, '0, 1'b0, '0);
        send_event(aad_pkg::FN_STARTUP, '0, 1'b0, '0);
        send_event(aad_pkg::FN_EXPIRY, '0, 1'b0, '0);
        send_event(aad_pkg::FN_EDGE, '0, 1'b0, '0);         // start at time zero means none
        send_event(aad_pkg::FN_EDGE, 48'd500, 1'b1, '0);
        send_event(aad_pkg::FN_EXPIRY, 48'd1000, 1'b0, '0);
        send_event(aad_pkg::FN_EXPIRY, 48'd350500, 1'b0, 12'd400);
        send_event(aad_pkg::FN_EDGE, 48'd400000, 1'b0, '0);
        send_event(aad_pkg::FN_EDGE, 48'd400500, 1'b1, '0);
        send_event(aad_pkg::FN_EXPIRY, 48'd750500, 1'b0, '0);
        send_event(aad_pkg::FN_EDGE, 48'd800000, 1'b0, '0);
        send_event(aad_pkg::FN_EDGE, 48'd800651, 1'b1, '0);  // one past the longest pulse
        send_event(aad_pkg::FN_EXPIRY, 48'd1150651, 1'b0, 12'd100);
        send_event(aad_pkg::FN_EDGE, 48'd1200000, 1'b1, '0);
        send_event(aad_pkg::FN_EXPIRY, 48'd1550000, 1'b0, 12'd401);
        send_event(aad_pkg::FN_EXPIRY, 48'd1550001, 1'b0, 12'd2699);
        send_event(aad_pkg::FN_EXPIRY, 48'd1550002, 1'b0, 12'd2700);
        send_event(aad_pkg::FN_EXPIRY, 48'd1550003, 1'b1, '0);
        send_event(aad_pkg::FN_FORCE_ATTACH, 48'd1550003, 1'b0, '0);
        send_event(aad_pkg::FN_EDGE, 48'd1600000, 1'b0, '0);
        send_event(aad_pkg::FN_FORCE_RESET, 48'd1600000, 1'b0, '0);
        send_event(aad_pkg::FN_FORCE_DETACH, 48'd1600000, 1'b0, '0);
        send_event(aad_pkg::FN_SHUTDOWN, 48'd1600000, 1'b0, '0);
        send_event(aad_pkg::FN_EXPIRY, 48'd1600000, 1'b0, 12'hFFF);
    endtask

    task automatic test_config_sweep();
        set_config(aad_pkg::AttachMaxRst, aad_pkg::DetachMinRst, aad_pkg::AssertDebRst,
                   aad_pkg::DeassertDebRst, aad_pkg::PulseMinRst, aad_pkg::PulseMaxRst);
        run_traffic(200);
        set_config(mv_t'($urandom_range(1500, 0)), mv_t'($urandom_range(4095, 1500)),
                   delay_t'($urandom_range(400000, 0)), delay_t'($urandom_range(50000, 0)),
                   pulse_t'($urandom_range(1000, 0)), pulse_t'($urandom_range(2000, 500)));
        run_traffic(200);
        set_config('0, '0, '0, '0, '0, '0);
        run_traffic(200);
        set_config('1, '1, '1, '1, '1, '1);
        run_traffic(200);
        // attach ceiling above detach floor
        set_config(12'd3000, 12'd1000, delay_t'($urandom_range(400000, 0)),
                   delay_t'($urandom_range(50000, 0)),
                   pulse_t'($urandom_range(1000, 0)), pulse_t'($urandom_range(2000, 500)));
        run_traffic(200);
    endtask

    task automatic test_input_backpressure();
        wait_idle();
        tx_bursty = 1'b0;
        hold_request = 1'b1;
        run_traffic(40);
        tx_bursty = 1'b1;
    endtask

    task automatic test_time_limits();
        time_t t;
        set_config(aad_pkg::AttachMaxRst, aad_pkg::DetachMinRst, aad_pkg::DelayMax,
                   aad_pkg::DelayMax, '0, '1);
        send_event(aad_pkg::FN_STARTUP, cur_time, 1'b0, '0);
        send_event(aad_pkg::FN_EDGE, TimeMax - 100, 1'b1, '0);      // deadline saturates
        send_event(aad_pkg::FN_EXPIRY, TimeMax - 5000000, 1'b0, '0);
        send_event(aad_pkg::FN_EXPIRY, TimeMax - 1000, 1'b0, '0);
        send_event(aad_pkg::FN_EXPIRY, TimeMax, 1'b0, '0);
        send_event(aad_pkg::FN_EDGE, TimeMax, 1'b0, 12'hFFF);
        send_event(aad_pkg::FN_EXPIRY, '0, 1'b1, 12'hFFF);
        repeat (30)
        begin
            t = time_t'({$urandom, $urandom});
            send_event(aad_pkg::func_t'($urandom_range(7, 0)), t, 1'($urandom_range(1, 0)),
                       rand_mv());
        end
    endtask

    // result side: free-running, random or patterned stalls, plus one long hold
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = HoldCycles;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(2, 0));
                    stall_pattern = 8'($urandom_range(255, 1));
                    mode_left = $urandom_range(200, 20);
                end
                mode_left--;
                case (rx_mode)
                    RX_FREE:   res_ch.ready <= 1'b1;
                    RX_RANDOM: res_ch.ready <= ($urandom_range(3, 0) != 0);
                    default:   res_ch.ready <= stall_pattern[mode_left % 8];
                endcase
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                got_word.dock   = res_ch.dock_state;
                got_word.slate  = res_ch.slate_mode;
                got_word.power  = res_ch.base_power_enable;
                got_word.wake   = res_ch.wake_event;
                got_word.treq   = res_ch.timer_request;
                got_word.delay  = res_ch.timer_delay_us;
                got_word.irq    = res_ch.irq_enabled;
                if (words_due.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MaxPrint)
                        $display("%0t: status word with none expected, expected none, actual %0d",
                                 $time, got_word.dock);
                end
                else
                begin
                    want_word = words_due.pop_front();
                    n_words++;
                    check_field("dock_state", time_t'(want_word.dock), time_t'(got_word.dock));
                    check_field("slate_mode", time_t'(want_word.slate),
                                time_t'(got_word.slate));
                    check_field("base_power_enable", time_t'(want_word.power),
                                time_t'(got_word.power));
                    check_field("wake_event", time_t'(want_word.wake), time_t'(got_word.wake));
                    check_field("timer_request", time_t'(want_word.treq),
                                time_t'(got_word.treq));
                    check_field("timer_delay_us", time_t'(want_word.delay),
                                time_t'(got_word.delay));
                    check_field("irq_enabled", time_t'(want_word.irq), time_t'(got_word.irq));
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IdleLimit)
        begin
            @(posedge clk);
            if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no word moved for %0d cycles, %0d still expected",
                 $time, IdleLimit, words_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        evt_ch.valid     = 1'b0;
        evt_ch.func      = '0;
        evt_ch.time_us   = '0;
        evt_ch.pin_level = 1'b0;
        evt_ch.adc_mv    = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_event_basics();
        test_config_sweep();
        test_input_backpressure();
        test_time_limits();
        wait_idle();

        $display("Sent %0d events plus %0d edges while disabled, across default, random,",
                 n_events, n_ignored);
        $display("zero, full-scale and overlapping settings: %0d words, %0d wakes, %0d timers",
                 n_words, n_wake, n_treq);
        if (n_errors == 0 && words_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- accessory_attach_detector.f -----
sv/aad_pkg.sv
sv/aad_evt_if.sv
sv/aad_res_if.sv
sv/aad_cfg_if.sv
sv/accessory_attach_detector.sv
sv/aad_checker.sv
bench/testbench.sv
